// File: hw/rtl/msc_pkg.sv
// Shared types and constants of the multiplexed pot scan conditioner.
package msc_pkg;

    localparam int VALUE_W    = 17;
    localparam int GAIN_W     = 16;
    localparam int SAMPLE_W   = 16;
    localparam int CHAN_W     = 4;
    localparam int MUX_W      = 4;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 17;
    localparam int FRAC_SHIFT = 12;
    localparam int PROD1_W    = SAMPLE_W + GAIN_W;
    localparam int V1_W       = PROD1_W - FRAC_SHIFT;
    localparam int PROD2_W    = V1_W + GAIN_W;
    localparam int V2_W       = PROD2_W - FRAC_SHIFT;

    localparam logic [VALUE_W-1:0] ONE_Q16  = 17'h10000;
    localparam logic [VALUE_W-1:0] HALF_Q16 = 17'h08000;

    typedef enum logic [1:0] {
        FUNC_SAMPLE      = 2'd0,
        FUNC_READ        = 2'd1,
        FUNC_READ_CENTER = 2'd2
    } func_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_SCALE_GAIN       = 3'd0,
        REG_FLOOR_LEVEL      = 3'd1,
        REG_FULL_SCALE_GAIN  = 3'd2,
        REG_EDGE_SNAP        = 3'd3,
        REG_CENTER_SNAP      = 3'd4,
        REG_JITTER_THRESHOLD = 3'd5
    } cfg_index_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_MUL1,
        ST_MUL2,
        ST_DONE
    } ctrl_state_t;

    typedef struct packed {
        logic [1:0]          func;
        logic [SAMPLE_W-1:0] sample;
        logic [MUX_W-1:0]    mux_index;
        logic [CHAN_W-1:0]   pot_index;
        logic                last_of_scan;
    } in_item_t;

    typedef struct packed {
        logic [VALUE_W-1:0] value;
        logic               changed;
        logic [CHAN_W-1:0]  mux_address;
    } out_item_t;

    typedef struct packed {
        logic [GAIN_W-1:0]  scale_gain;
        logic [VALUE_W-1:0] floor_level;
        logic [GAIN_W-1:0]  full_scale_gain;
        logic [GAIN_W-1:0]  edge_snap;
        logic [GAIN_W-1:0]  center_snap;
        logic [VALUE_W-1:0] jitter_threshold;
    } cfg_t;

    typedef struct packed {
        logic capture;
        logic stage1;
        logic stage2;
        logic finish;
    } ctrl_cmd_t;

    typedef struct packed {
        logic out_free;
    } ctrl_status_t;

endpackage

// File: hw/rtl/mux_pot_scan_conditioner.sv
// Top level of the multiplexed pot scan conditioner.
// Input beats (s_valid/s_ready, s_data) carry either a converter sample (func 0)
// or a read of a stored pot value (func 1 plain, func 2 snapped to one half when within center_snap of it).
// Every input beat yields exactly one output beat (m_valid/m_ready, m_data)
// holding the value, a changed flag and the next multiplexer address.
// Configuration registers are written through cfg_wr_en/cfg_index/cfg_wdata
// while the block is idle, a rule for the user that the block does not enforce;
// writes take effect at the next clock edge.
// An accepted item is captured, passes the MUL1 and MUL2 states and is registered
// into the output in DONE; a new item is accepted only once the previous one completes.
// The pot store is a 1-port RAM (MUX_COUNT*POTS_PER_MUX entries) with
// per-entry valid flags; unwritten entries read as zero.
// Reset (aresetn low, synchronous) clears valid flags, the channel counter and
// the output valid, loads config defaults, and leaves the block idle and ready.
// If the receiver stalls, the result holds in the output register; the next
// item is still accepted and processed, and waits before completion until
// the held beat is taken.
module mux_pot_scan_conditioner
    import msc_pkg::*;
#(
    parameter int MUX_COUNT    = 8,
    parameter int POTS_PER_MUX = 16
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_valid,
    output logic                  s_ready,
    input  in_item_t              s_data,
    output logic                  m_valid,
    input  logic                  m_ready,
    output out_item_t             m_data,
    input  logic                  cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_wdata
);

    cfg_t         cfg;
    ctrl_cmd_t    cmd;
    ctrl_status_t status;

    msc_cfg_regs u_cfg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .cfg       (cfg)
    );

    msc_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .status  (status),
        .cmd     (cmd)
    );

    msc_datapath #(
        .MUX_COUNT    (MUX_COUNT),
        .POTS_PER_MUX (POTS_PER_MUX)
    ) u_dp (
        .aclk    (aclk),
        .aresetn (aresetn),
        .cfg     (cfg),
        .s_data  (s_data),
        .cmd     (cmd),
        .status  (status),
        .m_ready (m_ready),
        .m_valid (m_valid),
        .m_data  (m_data)
    );

    a_busy_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> !s_ready)
        else $error("accepted a beat while the previous item was in work");

    a_addr_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> ({1'b0, m_data.mux_address} < (CHAN_W + 1)'(POTS_PER_MUX)))
        else $error("mux address out of range");

    a_value_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_data.value <= ONE_Q16))
        else $error("result value above full scale");

    a_one_result: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> ##2 !s_ready)
        else $error("item left the sequencer too early");

endmodule

// File: hw/rtl/msc_cfg_regs.sv
// Configuration register file of the pot scan conditioner.
module msc_cfg_regs
    import msc_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_wdata,
    output cfg_t                  cfg
);

    cfg_t cfg_reg;
    cfg_t cfg_next;

    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_wr_en) begin
            unique case (cfg_index)
                REG_SCALE_GAIN:       cfg_next.scale_gain       = cfg_wdata[GAIN_W-1:0];
                REG_FLOOR_LEVEL:      cfg_next.floor_level      = cfg_wdata[VALUE_W-1:0];
                REG_FULL_SCALE_GAIN:  cfg_next.full_scale_gain  = cfg_wdata[GAIN_W-1:0];
                REG_EDGE_SNAP:        cfg_next.edge_snap        = cfg_wdata[GAIN_W-1:0];
                REG_CENTER_SNAP:      cfg_next.center_snap      = cfg_wdata[GAIN_W-1:0];
                REG_JITTER_THRESHOLD: cfg_next.jitter_threshold = cfg_wdata[VALUE_W-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.scale_gain       <= 16'd4096;
            cfg_reg.floor_level      <= '0;
            cfg_reg.full_scale_gain  <= 16'd4096;
            cfg_reg.edge_snap        <= '0;
            cfg_reg.center_snap      <= '0;
            cfg_reg.jitter_threshold <= '0;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

// File: hw/rtl/msc_ctrl.sv
// Sequencing state machine of the pot scan conditioner.
module msc_ctrl
    import msc_pkg::*;
(
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_valid,
    output logic         s_ready,
    input  ctrl_status_t status,
    output ctrl_cmd_t    cmd
);

    ctrl_state_t state_reg;
    ctrl_state_t state_next;

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: if (s_valid) state_next = ST_MUL1;
            ST_MUL1: state_next = ST_MUL2;
            ST_MUL2: state_next = ST_DONE;
            ST_DONE: if (status.out_free) state_next = ST_IDLE;
            default: state_next = ST_IDLE;
        endcase
    end

    always_comb begin
        s_ready     = 1'b0;
        cmd.capture = 1'b0;
        cmd.stage1  = 1'b0;
        cmd.stage2  = 1'b0;
        cmd.finish  = 1'b0;
        unique case (state_reg)
            ST_IDLE: begin
                s_ready     = 1'b1;
                cmd.capture = s_valid;
            end
            ST_MUL1: cmd.stage1 = 1'b1;
            ST_MUL2: cmd.stage2 = 1'b1;
            ST_DONE: cmd.finish = status.out_free;
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

endmodule

// File: hw/rtl/msc_datapath.sv
// Datapath: conditioning multiplies, pot store, channel counter, output register.
module msc_datapath
    import msc_pkg::*;
#(
    parameter int MUX_COUNT    = 8,
    parameter int POTS_PER_MUX = 16
) (
    input  logic         aclk,
    input  logic         aresetn,
    input  cfg_t         cfg,
    input  in_item_t     s_data,
    input  ctrl_cmd_t    cmd,
    output ctrl_status_t status,
    input  logic         m_ready,
    output logic         m_valid,
    output out_item_t    m_data
);

    localparam int STORE_DEPTH = MUX_COUNT * POTS_PER_MUX;
    localparam int ADDR_W      = $clog2(STORE_DEPTH);
    localparam int IDX_W       = MUX_W + CHAN_W;
    localparam logic [CHAN_W-1:0] CHAN_LAST = CHAN_W'(POTS_PER_MUX - 1);

    in_item_t            in_reg;
    logic [CHAN_W-1:0]   channel_reg;
    logic [CHAN_W-1:0]   channel_next;
    logic [PROD1_W-1:0]  prod1_reg;
    logic [PROD2_W-1:0]  prod2_reg;
    logic [PROD2_W-1:0]  prod2_next;
    logic [VALUE_W-1:0]  rdata_reg;
    logic                rvalid_reg;
    logic [STORE_DEPTH-1:0] valid_reg;
    logic [VALUE_W-1:0]  mem [STORE_DEPTH];
    out_item_t           out_reg;
    out_item_t           out_next;
    logic                m_valid_reg;

    logic [CHAN_W-1:0]   sel_pot;
    logic                mux_ok;
    logic                pot_ok;
    logic [IDX_W-1:0]    idx_full;
    logic [ADDR_W-1:0]   addr;
    logic [V1_W-1:0]     v1;
    logic [V1_W-1:0]     floored;
    logic [V2_W-1:0]     v2;
    logic [VALUE_W-1:0]  clamped;
    logic [VALUE_W-1:0]  snap_hi;
    logic [VALUE_W-1:0]  cond;
    logic [VALUE_W-1:0]  old_val;
    logic [VALUE_W-1:0]  rd_val;
    logic [VALUE_W-1:0]  diff;
    logic [VALUE_W-1:0]  center_d;
    logic [VALUE_W-1:0]  centered;
    logic                upd;
    logic                is_sample;
    logic                store_we;

    assign is_sample = (in_reg.func == FUNC_SAMPLE);
    assign sel_pot   = is_sample ? channel_reg : in_reg.pot_index;
    assign mux_ok    = ({1'b0, in_reg.mux_index} < (MUX_W + 1)'(MUX_COUNT));
    assign pot_ok    = is_sample || ({1'b0, in_reg.pot_index} < (CHAN_W + 1)'(POTS_PER_MUX));
    assign idx_full  = IDX_W'(in_reg.mux_index) * IDX_W'(POTS_PER_MUX) + IDX_W'(sel_pot);
    assign addr      = idx_full[ADDR_W-1:0];

    // Stage 2: floor, then normalize
    assign v1         = prod1_reg[PROD1_W-1:FRAC_SHIFT];
    assign floored    = (v1 <= V1_W'(cfg.floor_level)) ? '0 : v1;
    assign prod2_next = PROD2_W'(floored) * PROD2_W'(cfg.full_scale_gain);

    // Clamp to 1.0 and snap near the ends
    assign v2      = prod2_reg[PROD2_W-1:FRAC_SHIFT];
    assign clamped = (v2 > V2_W'(ONE_Q16)) ? ONE_Q16 : v2[VALUE_W-1:0];
    assign snap_hi = ONE_Q16 - VALUE_W'(cfg.edge_snap);

    always_comb begin
        if (clamped <= VALUE_W'(cfg.edge_snap)) begin
            cond = '0;
        end else if (clamped >= snap_hi) begin
            cond = ONE_Q16;
        end else begin
            cond = clamped;
        end
    end

    assign old_val  = rvalid_reg ? rdata_reg : '0;
    assign rd_val   = (mux_ok && pot_ok) ? old_val : '0;
    assign diff     = (cond >= old_val) ? cond - old_val : old_val - cond;
    assign upd      = mux_ok && (diff >= cfg.jitter_threshold);
    assign center_d = (rd_val >= HALF_Q16) ? rd_val - HALF_Q16 : HALF_Q16 - rd_val;
    assign centered = (center_d <= VALUE_W'(cfg.center_snap)) ? HALF_Q16 : rd_val;
    assign store_we = cmd.finish && is_sample && upd;

    always_comb begin
        channel_next = channel_reg;
        if (cmd.finish && is_sample && in_reg.last_of_scan) begin
            channel_next = (channel_reg == CHAN_LAST) ? '0 : channel_reg + 1'b1;
        end
    end

    always_comb begin
        out_next.value       = '0;
        out_next.changed     = 1'b0;
        out_next.mux_address = channel_next;
        case (in_reg.func)
            FUNC_SAMPLE: begin
                out_next.changed = upd;
                if (!mux_ok || upd) begin
                    out_next.value = cond;
                end else begin
                    out_next.value = old_val;
                end
            end
            FUNC_READ:        out_next.value = rd_val;
            FUNC_READ_CENTER: out_next.value = centered;
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (cmd.capture) begin
            in_reg <= s_data;
        end
        if (cmd.stage1) begin
            prod1_reg  <= PROD1_W'(in_reg.sample) * PROD1_W'(cfg.scale_gain);
            rdata_reg  <= mem[addr];
            rvalid_reg <= valid_reg[addr];
        end
        if (cmd.stage2) begin
            prod2_reg <= prod2_next;
        end
        if (store_we) begin
            mem[addr] <= cond;
        end
        if (cmd.finish) begin
            out_reg <= out_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            channel_reg <= '0;
            valid_reg   <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            channel_reg <= channel_next;
            if (store_we) begin
                valid_reg[addr] <= 1'b1;
            end
            if (cmd.finish) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    assign status.out_free = !m_valid_reg || m_ready;
    assign m_valid         = m_valid_reg;
    assign m_data          = out_reg;

endmodule

// File: tb/mux_pot_scan_conditioner_test.sv
`timescale 1ns / 100ps
// Self-checking testbench for the pot scan conditioner: directed and random beats vs. a predictor.
module mux_pot_scan_conditioner_test;
    import msc_pkg::*;

    localparam int MUX_COUNT     = 8;
    localparam int POTS_PER_MUX  = 16;
    localparam int CYCLE_LIMIT   = 600000;
    localparam int DRAIN_CYCLES  = 8;
    localparam int RANDOM_PHASES = 8;
    localparam int PHASE_ITEMS   = 180;
    localparam logic [1:0] FUNC_UNUSED = 2'd3;

    logic                  aclk      = 1'b0;
    logic                  aresetn   = 1'b0;
    logic                  s_valid   = 1'b0;
    logic                  s_ready;
    in_item_t              s_data    = '0;
    logic                  m_valid;
    logic                  m_ready   = 1'b0;
    out_item_t             m_data;
    logic                  cfg_wr_en = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_wdata = '0;

    // predictor state
    logic [VALUE_W-1:0] pot_model [MUX_COUNT*POTS_PER_MUX];
    logic [CHAN_W-1:0]  scan_channel;
    logic [GAIN_W-1:0]  scale_gain_q, full_scale_q, edge_q, center_q;
    logic [VALUE_W-1:0] floor_q, jitter_q;

    out_item_t expected_results [$];
    in_item_t  pending_items [$];
    int        pushed_count   = 0;
    int        accepted_count = 0;
    int        mismatch_count = 0;
    int        cycle_count    = 0;
    int        send_gap       = 0;
    int        stall_left     = 0;
    bit        steady_flow    = 1'b0;
    logic      s_took         = 1'b0;

    // stimulus-side pot positions
    int                level_map [MUX_COUNT][POTS_PER_MUX];
    logic [CHAN_W-1:0] gen_channel = '0;

    mux_pot_scan_conditioner #(
        .MUX_COUNT    (MUX_COUNT),
        .POTS_PER_MUX (POTS_PER_MUX)
    ) i_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    always #4 aclk = ~aclk;

    function automatic logic [VALUE_W-1:0] stored_value(logic [MUX_W-1:0] m,
                                                        logic [CHAN_W-1:0] p);
        if (m >= MUX_COUNT || p >= POTS_PER_MUX) return '0;
        return pot_model[m * POTS_PER_MUX + p];
    endfunction

    function automatic out_item_t predict_result(in_item_t it);
        out_item_t          r;
        logic [63:0]        v;
        logic [VALUE_W-1:0] old, diff, cur;
        int                 idx;
        r = '0;
        case (it.func)
            FUNC_SAMPLE: begin
                v = (64'(it.sample) * scale_gain_q) >> FRAC_SHIFT;
                if (v <= floor_q) v = 0;
                v = (v * full_scale_q) >> FRAC_SHIFT;
                if (v > ONE_Q16) v = ONE_Q16;
                if (v <= edge_q) v = 0;
                else if (v >= ONE_Q16 - edge_q) v = ONE_Q16;
                cur = v[VALUE_W-1:0];
                if (it.mux_index < MUX_COUNT) begin
                    idx  = it.mux_index * POTS_PER_MUX + scan_channel;
                    old  = pot_model[idx];
                    diff = (cur >= old) ? cur - old : old - cur;
                    if (diff >= jitter_q) begin
                        pot_model[idx] = cur;
                        r.changed = 1'b1;
                    end
                    cur = pot_model[idx];
                end
                if (it.last_of_scan)
                    scan_channel = (scan_channel == POTS_PER_MUX - 1) ? '0 : scan_channel + 1'b1;
                r.value = cur;
            end
            FUNC_READ: r.value = stored_value(it.mux_index, it.pot_index);
            FUNC_READ_CENTER: begin
                cur  = stored_value(it.mux_index, it.pot_index);
                diff = (cur >= HALF_Q16) ? cur - HALF_Q16 : HALF_Q16 - cur;
                r.value = (diff <= center_q) ? HALF_Q16 : cur;
            end
            default: ;
        endcase
        r.mux_address = scan_channel;
        return r;
    endfunction

    function automatic int pick_pause();
        int r;
        if (steady_flow) return 0;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 90) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    function automatic int pick_level(int lo, int hi, int typ_lo, int typ_hi);
        int r;
        r = $urandom_range(0, 19);
        if (r == 0) return lo;
        if (r == 1) return hi;
        if (r < 5) return $urandom_range(lo, hi);
        return $urandom_range(typ_lo, typ_hi);
    endfunction

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("simulation failed");
            $finish;
        end
    end

    // input driver
    always @(negedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else if (!s_valid || s_took) begin
            if (send_gap > 0) begin
                s_valid  <= 1'b0;
                send_gap <= send_gap - 1;
            end else if (pending_items.size() != 0) begin
                s_data   <= pending_items.pop_front();
                s_valid  <= 1'b1;
                send_gap <= pick_pause();
            end else begin
                s_valid <= 1'b0;
            end
        end
    end

    // result receiver
    always @(negedge aclk) begin
        if (stall_left > 0) begin
            m_ready    <= 1'b0;
            stall_left <= stall_left - 1;
        end else begin
            m_ready    <= 1'b1;
            stall_left <= pick_pause();
        end
    end

    // monitor and checker
    always @(posedge aclk) begin
        out_item_t got, want;
        if (aresetn) begin
            if (m_valid && m_ready) begin
                got = m_data;
                if (expected_results.size() == 0) begin
                    $error("result beat with nothing expected: value %0d", got.value);
                    mismatch_count++;
                end else begin
                    want = expected_results.pop_front();
                    if (got.value !== want.value) begin
                        $error("value: expected %0d, actual %0d", want.value, got.value);
                        mismatch_count++;
                    end
                    if (got.changed !== want.changed) begin
                        $error("changed: expected %0d, actual %0d", want.changed, got.changed);
                        mismatch_count++;
                    end
                    if (got.mux_address !== want.mux_address) begin
                        $error("mux_address: expected %0d, actual %0d",
                               want.mux_address, got.mux_address);
                        mismatch_count++;
                    end
                end
            end
            if (s_valid && s_ready) begin
                expected_results.push_back(predict_result(s_data));
                accepted_count++;
            end
        end
        s_took <= aresetn && s_valid && s_ready;
    end

    task automatic write_reg(cfg_index_t idx, int val);
        @(negedge aclk);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= CFG_DATA_W'(val);
        @(negedge aclk);
        cfg_wr_en <= 1'b0;
        case (idx)
            REG_SCALE_GAIN:       scale_gain_q = val[GAIN_W-1:0];
            REG_FLOOR_LEVEL:      floor_q      = val[VALUE_W-1:0];
            REG_FULL_SCALE_GAIN:  full_scale_q = val[GAIN_W-1:0];
            REG_EDGE_SNAP:        edge_q       = val[GAIN_W-1:0];
            REG_CENTER_SNAP:      center_q     = val[GAIN_W-1:0];
            REG_JITTER_THRESHOLD: jitter_q     = val[VALUE_W-1:0];
            default: ;
        endcase
    endtask

    task automatic configure(int sg, int fl, int fs, int es, int cs, int jt);
        write_reg(REG_SCALE_GAIN, sg);
        write_reg(REG_FLOOR_LEVEL, fl);
        write_reg(REG_FULL_SCALE_GAIN, fs);
        write_reg(REG_EDGE_SNAP, es);
        write_reg(REG_CENTER_SNAP, cs);
        write_reg(REG_JITTER_THRESHOLD, jt);
    endtask

    task automatic push_item(int f, int smp, int mux, int pot, int last);
        in_item_t it;
        it.func         = 2'(f);
        it.sample       = SAMPLE_W'(smp);
        it.mux_index    = MUX_W'(mux);
        it.pot_index    = CHAN_W'(pot);
        it.last_of_scan = (last != 0);
        pending_items.push_back(it);
        pushed_count++;
    endtask

    task automatic wait_idle();
        while (accepted_count != pushed_count || expected_results.size() != 0)
            @(posedge aclk);
    endtask

    // one scan step: every mux at the current channel, last beat advances it; about one step in ten stops early
    task automatic push_scan();
        int lvl;
        int stop_at;
        stop_at = ($urandom_range(0, 9) == 0) ? $urandom_range(0, MUX_COUNT - 1) : MUX_COUNT;
        for (int m = 0; m < stop_at; m++) begin
            if ($urandom_range(0, 19) == 0)
                level_map[m][gen_channel] = $urandom_range(0, 65535);
            else
                level_map[m][gen_channel] += int'($urandom_range(0, 400)) - 200;
            lvl = level_map[m][gen_channel] + int'($urandom_range(0, 600)) - 300;
            if (lvl < 0) lvl = 0;
            if (lvl > 65535) lvl = 65535;
            push_item(FUNC_SAMPLE, lvl, m, $urandom_range(0, 15), m == MUX_COUNT - 1);
        end
        if (stop_at == MUX_COUNT) gen_channel = gen_channel + 1'b1;
    endtask

    initial begin
        int start;
        int r;
        foreach (pot_model[i]) pot_model[i] = '0;
        foreach (level_map[m, p]) level_map[m][p] = $urandom_range(0, 65535);
        scan_channel = '0;
        scale_gain_q = 16'd4096;
        floor_q      = '0;
        full_scale_q = 16'd4096;
        edge_q       = '0;
        center_q     = '0;
        jitter_q     = '0;

        repeat (11) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // reset settings: field extremes, out-of-range mux, unused code
        push_item(FUNC_SAMPLE, 16'h0000, 0, 0, 1'b0);
        push_item(FUNC_SAMPLE, 16'hFFFF, 7, 15, 1'b0);
        push_item(FUNC_SAMPLE, 16'h8000, 3, 0, 1'b1);
        push_item(FUNC_SAMPLE, 16'hFFFF, 8, 15, 1'b0);
        push_item(FUNC_SAMPLE, 16'h5555, 15, 0, 1'b1);
        push_item(FUNC_READ, 16'hFFFF, 7, 0, 1'b1);
        push_item(FUNC_READ, 16'h0000, 0, 15, 1'b0);
        push_item(FUNC_READ_CENTER, 16'h0000, 3, 0, 1'b0);
        push_item(FUNC_READ, 16'h0000, 8, 0, 1'b0);
        push_item(FUNC_READ_CENTER, 16'hFFFF, 15, 15, 1'b1);
        push_item(FUNC_UNUSED, 16'hFFFF, 15, 15, 1'b1);
        push_item(FUNC_SAMPLE, 16'hAAAA, 0, 10, 1'b1);
        wait_idle();

        // max gains, widest snaps, full-scale jitter threshold
        configure(65535, 0, 65535, 32768, 32768, 65536);
        push_item(FUNC_SAMPLE, 16'h0001, 2, 0, 1'b0);
        push_item(FUNC_SAMPLE, 16'hFFFF, 2, 0, 1'b1);
        push_item(FUNC_SAMPLE, 16'hFFFF, 8, 0, 1'b0);
        push_item(FUNC_READ_CENTER, 16'h0000, 2, 2, 1'b0);
        push_item(FUNC_READ_CENTER, 16'h0000, 9, 3, 1'b0);
        push_item(FUNC_READ_CENTER, 16'h0000, 7, 15, 1'b0);
        wait_idle();

        // floor and snap boundaries
        configure(4096, 1000, 4096, 100, 50, 300);
        push_item(FUNC_SAMPLE, 16'd1000, 1, 0, 1'b0);
        push_item(FUNC_SAMPLE, 16'd1001, 1, 0, 1'b0);
        push_item(FUNC_SAMPLE, 16'd65437, 1, 0, 1'b0);
        push_item(FUNC_SAMPLE, 16'd150, 4, 0, 1'b1);
        wait_idle();

        // zero gains, floor at full scale
        configure(0, 65536, 0, 0, 0, 0);
        push_item(FUNC_SAMPLE, 16'hFFFF, 0, 0, 1'b1);
        push_item(FUNC_READ, 16'h0000, 0, 0, 1'b0);
        wait_idle();

        for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
            steady_flow = (phase == 2);
            configure(pick_level(0, 65535, 3500, 5500), pick_level(0, 65536, 0, 2000),
                      pick_level(0, 65535, 3800, 4800), pick_level(0, 32768, 0, 1500),
                      pick_level(0, 32768, 0, 4000), pick_level(0, 65536, 0, 1200));
            start = pushed_count;
            while (pushed_count - start < PHASE_ITEMS) begin
                r = $urandom_range(0, 99);
                if (r < 65)
                    push_scan();
                else if (r < 85)
                    push_item(($urandom_range(0, 1) == 0) ? FUNC_READ : FUNC_READ_CENTER,
                              $urandom, ($urandom_range(0, 4) == 0) ? $urandom_range(0, 15)
                                        : $urandom_range(0, MUX_COUNT - 1),
                              $urandom_range(0, 15), $urandom_range(0, 1));
                else if (r < 95)
                    push_item(FUNC_SAMPLE, $urandom, $urandom_range(0, 15),
                              $urandom_range(0, 15), $urandom_range(0, 1));
                else
                    push_item(FUNC_UNUSED, $urandom, $urandom_range(0, 15),
                              $urandom_range(0, 15), $urandom_range(0, 1));
            end
            wait_idle();
        end

        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (mismatch_count == 0 && expected_results.size() == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule
